/* rtl/pal_pkg.sv */
`default_nettype none

package pal_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int WORD_W = 32;
    localparam int POS_W = 5;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_GET    = 2'd2
    } t_op;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef struct packed {
        logic             shift_up;
        logic             shift_down;
        logic [POS_W-1:0] pos_idx;
        t_word            value_in;
    } t_cell_cmd;

endpackage

`default_nettype wire

/* rtl/pal_if.sv */
`default_nettype none

interface pal_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                op;
    logic [4:0]                position;
    logic signed [31:0]        value_in;

    modport source (output valid, output op, output position, output value_in, input ready);
    modport sink (input valid, input op, input position, input value_in, output ready);
endinterface

interface pal_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      ok;
    logic signed [31:0]        value_out;
    logic [4:0]                count;

    modport source (output valid, output ok, output value_out, output count, input ready);
    modport sink (input valid, input ok, input value_out, input count, output ready);
endinterface

`default_nettype wire

/* rtl/pal_cell.sv */
`default_nettype none

module pal_cell #(
    parameter int INDEX = 0
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire pal_pkg::t_cell_cmd i_cmd,
    input  wire pal_pkg::t_word     i_left,
    input  wire pal_pkg::t_word     i_right,
    output pal_pkg::t_word          o_value
);
    import pal_pkg::*;

    t_word r_value;
    t_word n_value;

    always_comb begin
        n_value = r_value;
        if (i_cmd.shift_up) begin
            if (INDEX == int'(i_cmd.pos_idx)) begin
                n_value = i_cmd.value_in;
            end else if (INDEX > int'(i_cmd.pos_idx)) begin
                n_value = i_left;
            end
        end else if (i_cmd.shift_down) begin
            if (INDEX >= int'(i_cmd.pos_idx)) begin
                n_value = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
        end else begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

/* rtl/positional_array_list.sv */
// Positional array list: a bounded ordered list of signed 32-bit words.
// A request word on i_req carries op, position (1-based) and value_in.
// Insert places value_in at position and moves later entries up; delete
// removes and returns the entry at position and moves later entries down;
// get returns the entry at position. Each request yields one response word
// on o_rsp with ok, value_out and the count after the request.
// The entries live in a row of cells that all shift in the same cycle.
// The response is registered and appears on o_rsp in the cycle after the
// request is accepted; a new request is taken in every cycle while the
// response register is empty or drained, giving a throughput of one word
// per cycle.
// When the receiver stalls, the response is held and i_req.ready falls
// until the response is taken; no word is lost or dropped.
// A synchronous active-low reset clears every entry, the count and the
// response valid bit (not its data); the block is ready in the next cycle.
`default_nettype none

module positional_array_list #(
    parameter int CAPACITY = pal_pkg::DEFAULT_CAPACITY
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    pal_req_if.sink    i_req,
    pal_rsp_if.source  o_rsp
);
    import pal_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW + 1 : POS_W + 1;
    localparam int CXW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int NSEL = (CAPACITY < 31) ? CAPACITY : 31;

    t_word             cell_val [CAPACITY];
    t_cell_cmd         cmd;

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_valid;
    logic              r_ok;
    t_word             r_value;
    logic [COUNT_W-1:0] r_count_out;
    logic [CXW-1:0]    count_ext;

    logic              accept;
    logic              ins_ok;
    logic              rd_ok;
    logic [PW-1:0]     pos_w;
    logic [PW-1:0]     cnt_w;
    logic [POS_W-1:0]  pos_idx;
    t_word             sel_val;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        t_word left_val;
        t_word right_val;
        if (gi == 0) begin : g_first
            assign left_val = '0;
        end else begin : g_mid_l
            assign left_val = cell_val[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_last
            assign right_val = '0;
        end else begin : g_mid_r
            assign right_val = cell_val[gi+1];
        end
        pal_cell #(
            .INDEX(gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_left  (left_val),
            .i_right (right_val),
            .o_value (cell_val[gi])
        );
    end

    assign i_req.ready = !r_valid || o_rsp.ready;
    assign accept = i_req.valid && i_req.ready;

    assign pos_w = PW'(i_req.position);
    assign cnt_w = PW'(r_count);
    assign pos_idx = i_req.position - POS_W'(1);

    assign ins_ok = (i_req.op == OP_INSERT) && (i_req.position != '0)
                    && (pos_w <= cnt_w + PW'(1)) && (cnt_w < PW'(CAPACITY));
    assign rd_ok = ((i_req.op == OP_DELETE) || (i_req.op == OP_GET))
                   && (i_req.position != '0) && (pos_w <= cnt_w);

    always_comb begin
        sel_val = '0;
        for (int i = 0; i < NSEL; i++) begin
            if (POS_W'(i) == pos_idx) begin
                sel_val = cell_val[i];
            end
        end
    end

    always_comb begin
        cmd.shift_up   = accept && ins_ok;
        cmd.shift_down = accept && rd_ok && (i_req.op == OP_DELETE);
        cmd.pos_idx    = pos_idx;
        cmd.value_in   = i_req.value_in;
    end

    always_comb begin
        n_count = r_count;
        if (cmd.shift_up) begin
            n_count = r_count + CW'(1);
        end else if (cmd.shift_down) begin
            n_count = r_count - CW'(1);
        end
    end

    assign count_ext = CXW'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ok        <= ins_ok || rd_ok;
            r_value     <= rd_ok ? sel_val : '0;
            r_count_out <= count_ext[COUNT_W-1:0];
        end
    end

    assign o_rsp.valid     = r_valid;
    assign o_rsp.ok        = r_ok;
    assign o_rsp.value_out = r_value;
    assign o_rsp.count     = r_count_out;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (PW'(r_count) <= PW'(CAPACITY)))
        else $error("fill count exceeds capacity");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ins_ok) |=> (r_count == CW'($past(r_count) + CW'(1))))
        else $error("successful insert did not raise the count");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_ok) |-> (r_value == '0))
        else $error("failed request returned a nonzero word");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_rsp.ready) |-> !i_req.ready)
        else $error("request taken while response is stalled");
`endif

endmodule

`default_nettype wire
